>>> sv/gnd_pkg.sv
// Shared types and constants for the note dispenser chain.
package gnd_pkg;

	localparam int STOCK_BITS    = 12;
	localparam int AMOUNT_BITS   = 20;
	localparam int AMT_PORT_BITS = 20;
	localparam int COUNT_BITS    = 12;
	localparam int TAKEN_BITS    = 12;
	localparam int SHORT_BITS    = 20;
	localparam int NOTE_BITS     = 10;
	localparam int NUM_CELLS     = 4;
	localparam int CELL_IDX_BITS = $clog2(NUM_CELLS);
	localparam int WIDE_BITS     = AMOUNT_BITS + STOCK_BITS + NOTE_BITS;

	localparam logic [STOCK_BITS-1:0] STOCK_MAX = {STOCK_BITS{1'b1}};

	// Note values, largest first; cell k serves NOTE_VALUE[k]
	localparam logic [NOTE_BITS-1:0] NOTE_VALUE [NUM_CELLS] = '{
		NOTE_BITS'(1000), NOTE_BITS'(500), NOTE_BITS'(200), NOTE_BITS'(100)
	};

	// floor(2^AMOUNT_BITS / value): the estimated quotient is low by at most one
	localparam logic [AMOUNT_BITS-1:0] NOTE_RECIP [NUM_CELLS] = '{
		AMOUNT_BITS'((64'd1 << AMOUNT_BITS) / 64'd1000),
		AMOUNT_BITS'((64'd1 << AMOUNT_BITS) / 64'd500),
		AMOUNT_BITS'((64'd1 << AMOUNT_BITS) / 64'd200),
		AMOUNT_BITS'((64'd1 << AMOUNT_BITS) / 64'd100)
	};

	typedef enum logic {
		OP_WITHDRAW = 1'b0,
		OP_REFILL   = 1'b1
	} op_t;

	// One transaction as it travels down the chain
	typedef struct packed {
		op_t                                   op;
		logic [CELL_IDX_BITS-1:0]              denom;
		logic [COUNT_BITS-1:0]                 count;
		logic [AMOUNT_BITS-1:0]                rem;
		logic [NUM_CELLS-1:0][STOCK_BITS-1:0]  taken;
	} item_t;

endpackage

>>> sv/gnd_cell.sv
// One denomination cell: holds its note stock and serves each passing transaction.
module gnd_cell import gnd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CELL_IDX_BITS-1:0] cell_idx,
	input  logic                     in_vld,
	output logic                     in_rdy,
	input  item_t                    in_item,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output item_t                    out_item
);

	logic [NOTE_BITS-1:0]              note;
	logic [AMOUNT_BITS-1:0]            recip;
	logic [2*AMOUNT_BITS-1:0]          prod;
	logic [AMOUNT_BITS+NOTE_BITS-1:0]  qd;
	logic [STOCK_BITS+NOTE_BITS-1:0]   sd;
	logic                              rdy_s1;
	logic                              rdy_s2;
	logic                              load_s1;
	logic                              load_s2;
	logic                              vld_s1;
	logic                              vld_s2;
	item_t                             item_s1;
	item_t                             item_s2;
	logic [AMOUNT_BITS-1:0]            q0_s1;
	logic [STOCK_BITS-1:0]             stock_q;
	logic [WIDE_BITS-1:0]              a_w;
	logic [WIDE_BITS-1:0]              d_w;
	logic [WIDE_BITS-1:0]              q0_w;
	logic [WIDE_BITS-1:0]              r0_w;
	logic [WIDE_BITS-1:0]              q_w;
	logic [WIDE_BITS-1:0]              r_w;
	logic [WIDE_BITS-1:0]              stk_w;
	logic [WIDE_BITS-1:0]              take_w;
	logic [WIDE_BITS-1:0]              left_w;
	logic [WIDE_BITS-1:0]              sum_w;
	logic [STOCK_BITS-1:0]             stock_d;
	item_t                             item_d;

	assign note  = NOTE_VALUE[cell_idx];
	assign recip = NOTE_RECIP[cell_idx];

	// Advance each stage when it is empty or its successor takes its contents
	assign rdy_s2  = !vld_s2 || out_rdy;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign in_rdy  = rdy_s1;
	assign load_s1 = in_vld && rdy_s1;
	assign load_s2 = vld_s1 && rdy_s2;

	// Estimate the quotient with a reciprocal multiply
	assign prod = {{AMOUNT_BITS{1'b0}}, in_item.rem} * {{AMOUNT_BITS{1'b0}}, recip};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_item;
			q0_s1   <= prod[2*AMOUNT_BITS-1:AMOUNT_BITS];
		end
	end

	// Value of the estimated notes and of the whole stock, side by side
	assign qd = {{NOTE_BITS{1'b0}}, q0_s1} * {{AMOUNT_BITS{1'b0}}, note};
	assign sd = {{NOTE_BITS{1'b0}}, stock_q} * {{STOCK_BITS{1'b0}}, note};

	// Correct the quotient, clamp it to the stock and update the stock;
	// a short stock pays out all it has and the rest passes on
	always_comb begin
		a_w    = WIDE_BITS'(item_s1.rem);
		d_w    = WIDE_BITS'(note);
		q0_w   = WIDE_BITS'(q0_s1);
		r0_w   = a_w - WIDE_BITS'(qd);
		q_w    = (r0_w >= d_w) ? q0_w + WIDE_BITS'(1) : q0_w;
		r_w    = (r0_w >= d_w) ? r0_w - d_w : r0_w;
		stk_w  = WIDE_BITS'(stock_q);
		take_w = (q_w < stk_w) ? q_w : stk_w;
		left_w = (q_w < stk_w) ? r_w : a_w - WIDE_BITS'(sd);
		sum_w  = stk_w + WIDE_BITS'(item_s1.count);
		item_d = item_s1;
		stock_d = stock_q;
		item_d.taken = {item_s1.taken[NUM_CELLS-2:0], {STOCK_BITS{1'b0}}};
		unique case (item_s1.op)
			OP_WITHDRAW: begin
				stock_d      = STOCK_BITS'(stk_w - take_w);
				item_d.rem   = AMOUNT_BITS'(left_w);
				item_d.taken = {item_s1.taken[NUM_CELLS-2:0], STOCK_BITS'(take_w)};
			end
			OP_REFILL: begin
				if (item_s1.denom == cell_idx) begin
					stock_d = (sum_w > WIDE_BITS'(STOCK_MAX)) ? STOCK_MAX
						: STOCK_BITS'(sum_w);
				end
			end
			default: begin
				stock_d = stock_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			stock_q <= '0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (load_s2) begin
				stock_q <= stock_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= item_d;
		end
	end

	assign out_vld  = vld_s2;
	assign out_item = item_s2;

endmodule

>>> sv/greedy_note_dispenser.sv
// Top level of the note dispenser: four denomination cells and the result register.
//
// Request channel (req_valid / req_stall) carries operation, amount, denomination
// and note_count. A withdraw transaction walks the cells 1000, 500, 200, 100 in
// that order; each takes as many notes as fit, limited by its stock. A refill
// transaction adds note_count to one stock, saturating at the stock maximum, and
// returns an all-zero result.
// Response channel (rsp_valid / rsp_stall) carries the four taken counts, the
// shortfall and short_flag, one result per request, in request order.
// A result passes two register stages in each of the four cells, then the
// output register, on its way to the response ports. While the receiver does
// not stall, one transaction per cycle enters; each cell's stock is read and
// written in its last stage, so a transaction follows its predecessor directly.
// Reset empties all four stocks and the pipeline.
// When the receiver stalls, the result holds on the ports; the chain keeps
// filling its empty stages and raises req_stall only once every stage is full.
module greedy_note_dispenser import gnd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     operation,
	input  logic [AMT_PORT_BITS-1:0] amount,
	input  logic [1:0]               denomination,
	input  logic [COUNT_BITS-1:0]    note_count,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [TAKEN_BITS-1:0]    taken_thousands,
	output logic [TAKEN_BITS-1:0]    taken_five_hundreds,
	output logic [TAKEN_BITS-1:0]    taken_two_hundreds,
	output logic [TAKEN_BITS-1:0]    taken_hundreds,
	output logic [SHORT_BITS-1:0]    shortfall,
	output logic                     short_flag
);

	logic  [NUM_CELLS:0] vld;
	logic  [NUM_CELLS:0] rdy;
	item_t               item [NUM_CELLS+1];
	logic                out_vld_q;
	logic                out_load;

	// Build the entry transaction; a refill enters with nothing to pay out
	always_comb begin
		item[0].op    = op_t'(operation);
		item[0].denom = CELL_IDX_BITS'(denomination);
		item[0].count = note_count;
		item[0].rem   = (op_t'(operation) == OP_REFILL) ? '0 : AMOUNT_BITS'(amount);
		item[0].taken = '0;
	end

	assign vld[0]    = req_valid;
	assign req_stall = !rdy[0];

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		gnd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CELL_IDX_BITS'(k)),
			.in_vld   (vld[k]),
			.in_rdy   (rdy[k]),
			.in_item  (item[k]),
			.out_vld  (vld[k+1]),
			.out_rdy  (rdy[k+1]),
			.out_item (item[k+1])
		);
	end

	// Hold the result until the receiver takes it
	assign rdy[NUM_CELLS] = !out_vld_q || !rsp_stall;
	assign out_load       = vld[NUM_CELLS] && rdy[NUM_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rdy[NUM_CELLS]) begin
			out_vld_q <= vld[NUM_CELLS];
		end
	end

	// The first cell's count has been shifted to the top of the taken array
	always_ff @(posedge clk) begin
		if (out_load) begin
			taken_thousands     <= TAKEN_BITS'(item[NUM_CELLS].taken[3]);
			taken_five_hundreds <= TAKEN_BITS'(item[NUM_CELLS].taken[2]);
			taken_two_hundreds  <= TAKEN_BITS'(item[NUM_CELLS].taken[1]);
			taken_hundreds      <= TAKEN_BITS'(item[NUM_CELLS].taken[0]);
			shortfall           <= SHORT_BITS'(item[NUM_CELLS].rem);
			short_flag          <= (item[NUM_CELLS].rem != '0);
		end
	end

	assign rsp_valid = out_vld_q;

endmodule

>>> sv/gnd_chk.sv
// Port-level checker for the note dispenser and its bind to the top level.
module gnd_chk import gnd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_stall,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic [SHORT_BITS-1:0]    shortfall,
	input logic                     short_flag
);

	// Keep a stalled result on the port
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(shortfall) && $stable(short_flag))
		else $error("stalled response changed");

	// Back-pressure the requester only when the receiver holds a full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with free output");

	// A clear flag means nothing was left unpaid
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !short_flag |-> shortfall == '0)
		else $error("shortfall without flag");

endmodule

bind greedy_note_dispenser gnd_chk u_gnd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.shortfall  (shortfall),
	.short_flag (short_flag)
);
